// ===== src/tple_pkg.sv =====
`default_nettype none

package tple_pkg;

    localparam int OFFSET_BITS = 20;
    localparam int PITCH_BITS  = 20;
    localparam int EXT_BITS    = 64;

    localparam logic [7:0] PAN_RESET = 8'h40;
    localparam logic [7:0] PAN_MAX   = 8'h7f;

    typedef enum logic [2:0] {
        FUNC_TICK       = 3'd0,
        FUNC_SET_PAN    = 3'd1,
        FUNC_ADJ_PAN    = 3'd2,
        FUNC_LFO_CFG    = 3'd3,
        FUNC_LFO_ENABLE = 3'd4,
        FUNC_ENV_CFG    = 3'd5,
        FUNC_ENV_ENABLE = 3'd6,
        FUNC_NOTE_ON    = 3'd7
    } func_t;

    typedef struct packed {
        func_t             func;
        logic        [7:0] value;
        logic        [7:0] step;
        logic        [7:0] period;
        logic signed [4:0] amount;
        logic              flag;
    } cmd_t;

    typedef struct packed {
        logic              [7:0] pan_now;
        logic [PITCH_BITS-1:0]   pitch_offset;
        logic                    bend_event;
        logic                    lfo_active;
        logic                    env_active;
    } result_t;

endpackage

`default_nettype wire

// ===== src/tple_core.sv =====
`default_nettype none

module tple_core
    import tple_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    update,
    input  wire cmd_t    cmd,
    output result_t      result
);

    logic [7:0] pan_pos_reg, pan_pos_next;
    logic [7:0] lfo_low_reg, lfo_low_next;
    logic [7:0] lfo_high_reg, lfo_high_next;
    logic [7:0] lfo_step_reg, lfo_step_next;
    logic [7:0] lfo_period_reg, lfo_period_next;
    logic [7:0] lfo_count_reg, lfo_count_next;
    logic       lfo_down_reg, lfo_down_next;
    logic       lfo_on_reg, lfo_on_next;
    logic [7:0] env_delay_reg, env_delay_next;
    logic [7:0] env_depth_reg, env_depth_next;
    logic [7:0] env_period_reg, env_period_next;
    logic [7:0] env_count_reg, env_count_next;
    logic signed [OFFSET_BITS-1:0] env_offset_reg, env_offset_next;
    logic       env_on_reg, env_on_next;
    logic       bend;

    logic signed [OFFSET_BITS:0]   off_ext;
    logic signed [OFFSET_BITS:0]   off_sum;
    logic signed [OFFSET_BITS-1:0] off_sat;
    logic [7:0]                    env_mag;
    logic [7:0]                    lfo_cnt_dec;
    logic signed [9:0]             lfo_next;
    logic signed [9:0]             adj_sum;
    logic [EXT_BITS-1:0]           off_wide;

    always_comb
    begin
        off_ext = {env_offset_reg[OFFSET_BITS-1], env_offset_reg};
        if (env_period_reg[7])
            off_sum = off_ext - $signed({{(OFFSET_BITS-7){1'b0}}, env_depth_reg});
        else
            off_sum = off_ext + $signed({{(OFFSET_BITS-7){1'b0}}, env_depth_reg});
        if (off_sum[OFFSET_BITS] != off_sum[OFFSET_BITS-1])
            off_sat = off_sum[OFFSET_BITS] ? {1'b1, {(OFFSET_BITS-1){1'b0}}}
                                           : {1'b0, {(OFFSET_BITS-1){1'b1}}};
        else
            off_sat = off_sum[OFFSET_BITS-1:0];
        env_mag = env_period_reg[7] ? 8'(8'd0 - env_period_reg) : env_period_reg;

        lfo_cnt_dec = lfo_count_reg - 8'd1;
        if (lfo_down_reg)
            lfo_next = $signed({2'b00, pan_pos_reg}) - $signed({2'b00, lfo_step_reg});
        else
            lfo_next = $signed({2'b00, pan_pos_reg}) + $signed({2'b00, lfo_step_reg});

        adj_sum = $signed({2'b00, pan_pos_reg}) + 10'(cmd.amount);
    end

    always_comb
    begin
        pan_pos_next    = pan_pos_reg;
        lfo_low_next    = lfo_low_reg;
        lfo_high_next   = lfo_high_reg;
        lfo_step_next   = lfo_step_reg;
        lfo_period_next = lfo_period_reg;
        lfo_count_next  = lfo_count_reg;
        lfo_down_next   = lfo_down_reg;
        lfo_on_next     = lfo_on_reg;
        env_delay_next  = env_delay_reg;
        env_depth_next  = env_depth_reg;
        env_period_next = env_period_reg;
        env_count_next  = env_count_reg;
        env_offset_next = env_offset_reg;
        env_on_next     = env_on_reg;
        bend            = 1'b0;

        unique case (cmd.func)
            FUNC_TICK:
            begin
                if (env_on_reg)
                begin
                    if (env_count_reg != 8'd0)
                        env_count_next = env_count_reg - 8'd1;
                    else
                    begin
                        env_offset_next = off_sat;
                        env_count_next  = env_mag - 8'd1;
                        bend            = 1'b1;
                    end
                end
                if (lfo_on_reg)
                begin
                    lfo_count_next = lfo_cnt_dec;
                    if (lfo_cnt_dec == 8'd0)
                    begin
                        lfo_count_next = lfo_period_reg;
                        pan_pos_next   = lfo_next[7:0];
                        if (!lfo_down_reg && lfo_next >= $signed({2'b00, lfo_high_reg}))
                        begin
                            pan_pos_next  = lfo_high_reg;
                            lfo_down_next = 1'b1;
                        end
                        else if (lfo_down_reg
                                 && lfo_next <= $signed({2'b00, lfo_low_reg}))
                        begin
                            pan_pos_next  = lfo_low_reg;
                            lfo_down_next = 1'b0;
                        end
                    end
                end
            end
            FUNC_SET_PAN:
            begin
                lfo_on_next  = 1'b0;
                pan_pos_next = cmd.value;
            end
            FUNC_ADJ_PAN:
            begin
                if (adj_sum < 10'sd0)
                    pan_pos_next = 8'd0;
                else if (adj_sum > $signed({2'b00, PAN_MAX}))
                    pan_pos_next = PAN_MAX;
                else
                    pan_pos_next = adj_sum[7:0];
            end
            FUNC_LFO_CFG:
            begin
                lfo_low_next    = (cmd.value < pan_pos_reg) ? cmd.value : pan_pos_reg;
                lfo_high_next   = (cmd.value > pan_pos_reg) ? cmd.value : pan_pos_reg;
                lfo_down_next   = cmd.value < pan_pos_reg;
                lfo_step_next   = cmd.step;
                lfo_period_next = cmd.period;
                lfo_count_next  = cmd.period;
                lfo_on_next     = cmd.step != 8'd0;
            end
            FUNC_LFO_ENABLE:
                lfo_on_next = cmd.flag && (lfo_step_reg != 8'd0);
            FUNC_ENV_CFG:
            begin
                env_delay_next  = cmd.value;
                env_depth_next  = cmd.step;
                env_period_next = cmd.period;
                env_count_next  = cmd.value;
                env_on_next     = cmd.step != 8'd0;
            end
            FUNC_ENV_ENABLE:
                env_on_next = cmd.flag && (env_depth_reg != 8'd0);
            FUNC_NOTE_ON:
            begin
                bend            = env_offset_reg != '0;
                env_offset_next = '0;
                env_count_next  = env_delay_reg;
            end
            default:
                bend = 1'b0;
        endcase

        off_wide = {{(EXT_BITS-OFFSET_BITS){env_offset_next[OFFSET_BITS-1]}},
                    env_offset_next};
        result.pan_now      = pan_pos_next;
        result.pitch_offset = off_wide[PITCH_BITS-1:0];
        result.bend_event   = bend;
        result.lfo_active   = lfo_on_next;
        result.env_active   = env_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_pos_reg    <= PAN_RESET;
            lfo_low_reg    <= PAN_RESET;
            lfo_high_reg   <= PAN_RESET;
            lfo_step_reg   <= 8'd0;
            lfo_period_reg <= 8'd0;
            lfo_count_reg  <= 8'd0;
            lfo_down_reg   <= 1'b0;
            lfo_on_reg     <= 1'b0;
            env_delay_reg  <= 8'd0;
            env_depth_reg  <= 8'd0;
            env_period_reg <= 8'd0;
            env_count_reg  <= 8'd0;
            env_offset_reg <= '0;
            env_on_reg     <= 1'b0;
        end
        else if (update)
        begin
            pan_pos_reg    <= pan_pos_next;
            lfo_low_reg    <= lfo_low_next;
            lfo_high_reg   <= lfo_high_next;
            lfo_step_reg   <= lfo_step_next;
            lfo_period_reg <= lfo_period_next;
            lfo_count_reg  <= lfo_count_next;
            lfo_down_reg   <= lfo_down_next;
            lfo_on_reg     <= lfo_on_next;
            env_delay_reg  <= env_delay_next;
            env_depth_reg  <= env_depth_next;
            env_period_reg <= env_period_next;
            env_count_reg  <= env_count_next;
            env_offset_reg <= env_offset_next;
            env_on_reg     <= env_on_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/track_pan_lfo_pitch_envelope_unit.sv =====
`default_nettype none

// Per-track pan LFO / pitch envelope unit.
// Input stream (s_axis): one command request per transfer, func in tuser,
// operands in tdata. Output stream (m_axis): exactly one result per command,
// giving pan, pitch offset, bend flag and the LFO/envelope enables after it.
// Path: input register, then state update and result register in the same edge.
// Throughput: one command per cycle while the receiver takes the results.
// A stalled receiver holds the result register; one more request is still
// taken into the input register, after which s_axis_tready drops.
// Reset: pan and LFO bounds at 0x40, every other field zero, both units off,
// pipeline empty.
module track_pan_lfo_pitch_envelope_unit
    import tple_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // value[7:0], step[15:8], period[23:16], amount[28:24], flag[29], zero pad
    input  wire logic [31:0] s_axis_tdata,
    // func[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pan_now[7:0], pitch_offset[27:8], bend_event[28], lfo_active[29],
    // env_active[30], zero pad
    output logic [31:0]      m_axis_tdata
);

    logic    in_valid_reg;
    cmd_t    in_cmd_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;
    logic    advance;
    logic    update;
    cmd_t    cmd_in;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign update        = advance && in_valid_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        cmd_in.func   = func_t'(s_axis_tuser);
        cmd_in.value  = s_axis_tdata[7:0];
        cmd_in.step   = s_axis_tdata[15:8];
        cmd_in.period = s_axis_tdata[23:16];
        cmd_in.amount = s_axis_tdata[28:24];
        cmd_in.flag   = s_axis_tdata[29];
    end

    tple_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (update),
        .cmd    (in_cmd_reg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_cmd_reg <= cmd_in;
        if (update)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.env_active, out_res_reg.lfo_active,
                            out_res_reg.bend_event, out_res_reg.pitch_offset,
                            out_res_reg.pan_now};

    a_update_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> m_axis_tvalid)
        else $error("result missing after state update");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_cmd_reg))
        else $error("pending request lost while output stalled");

    a_rose_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg))
        else $error("result produced without a request");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input blocked with empty input register");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import tple_pkg::*;

    localparam int     STALL_LIMIT = 2000;
    localparam int     RAND_ITEMS  = 1420;
    localparam longint OFS_MAX     = (longint'(1) <<< (OFFSET_BITS - 1)) - 1;
    localparam longint OFS_MIN     = -OFS_MAX - 1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = FUNC_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    track_pan_lfo_pitch_envelope_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [7:0]                    pan_q;
    logic [7:0]                    lfo_lo, lfo_hi, lfo_inc, lfo_reload, lfo_cnt;
    logic                          lfo_falling, lfo_run;
    logic [7:0]                    env_wait, env_amt, env_int, env_cnt;
    logic signed [OFFSET_BITS-1:0] env_ofs;
    logic                          env_run;

    cmd_t    queued_cmds[$];
    result_t pending_results[$];
    cmd_t    in_flight;
    int      cmds_taken = 0;
    int      results_seen = 0;
    int      errors = 0;
    int      bends = 0;
    int      sat_hits = 0;
    int      stall_cycles = 0;

    function automatic int idle_pct();
        return (cmds_taken >= 300 && cmds_taken < 800) ? 0 : 30;
    endfunction

    function automatic logic pitch_env_tick();
        longint w;
        logic [7:0] mag;
        if (!env_run)
            return 1'b0;
        if (env_cnt != 8'd0)
        begin
            env_cnt = env_cnt - 8'd1;
            return 1'b0;
        end
        if (env_int[7])
        begin
            w   = longint'(env_ofs) - longint'(env_amt);
            mag = 8'd0 - env_int;
        end
        else
        begin
            w   = longint'(env_ofs) + longint'(env_amt);
            mag = env_int;
        end
        if (w > OFS_MAX)
        begin
            w = OFS_MAX;
            sat_hits++;
        end
        else if (w < OFS_MIN)
        begin
            w = OFS_MIN;
            sat_hits++;
        end
        env_ofs = w[OFFSET_BITS-1:0];
        env_cnt = mag - 8'd1;
        return 1'b1;
    endfunction

    function automatic void pan_lfo_tick();
        int nxt;
        if (!lfo_run)
            return;
        lfo_cnt = lfo_cnt - 8'd1;
        if (lfo_cnt != 8'd0)
            return;
        nxt = lfo_falling ? int'(pan_q) - int'(lfo_inc) : int'(pan_q) + int'(lfo_inc);
        if (!lfo_falling && nxt >= int'(lfo_hi))
        begin
            nxt = int'(lfo_hi);
            lfo_falling = 1'b1;
        end
        else if (lfo_falling && nxt <= int'(lfo_lo))
        begin
            nxt = int'(lfo_lo);
            lfo_falling = 1'b0;
        end
        pan_q   = nxt[7:0];
        lfo_cnt = lfo_reload;
    endfunction

    function automatic result_t next_track_state(cmd_t c);
        result_t r;
        logic    bend;
        int      p;
        longint  ofs_ext;
        bend = 1'b0;
        case (c.func)
            FUNC_TICK:
            begin
                bend = pitch_env_tick();
                pan_lfo_tick();
            end
            FUNC_SET_PAN:
            begin
                lfo_run = 1'b0;
                pan_q   = c.value;
            end
            FUNC_ADJ_PAN:
            begin
                p = int'(pan_q) + int'(c.amount);
                if (p < 0)
                    p = 0;
                if (p > int'(PAN_MAX))
                    p = int'(PAN_MAX);
                pan_q = p[7:0];
            end
            FUNC_LFO_CFG:
            begin
                lfo_lo      = (c.value < pan_q) ? c.value : pan_q;
                lfo_hi      = (c.value > pan_q) ? c.value : pan_q;
                lfo_falling = c.value < pan_q;
                lfo_inc     = c.step;
                lfo_reload  = c.period;
                lfo_cnt     = c.period;
                lfo_run     = c.step != 8'd0;
            end
            FUNC_LFO_ENABLE:
                lfo_run = c.flag && lfo_inc != 8'd0;
            FUNC_ENV_CFG:
            begin
                env_wait = c.value;
                env_amt  = c.step;
                env_int  = c.period;
                env_cnt  = c.value;
                env_run  = c.step != 8'd0;
            end
            FUNC_ENV_ENABLE:
                env_run = c.flag && env_amt != 8'd0;
            default:
            begin
                bend    = env_ofs != '0;
                env_ofs = '0;
                env_cnt = env_wait;
            end
        endcase
        ofs_ext        = longint'(env_ofs);
        r.pan_now      = pan_q;
        r.pitch_offset = ofs_ext[PITCH_BITS-1:0];
        r.bend_event   = bend;
        r.lfo_active   = lfo_run;
        r.env_active   = env_run;
        if (bend)
            bends++;
        return r;
    endfunction

    function automatic cmd_t mk_cmd(func_t f, logic [7:0] v, logic [7:0] s, logic [7:0] per,
                                    int amt, logic flg);
        cmd_t c;
        c.func   = f;
        c.value  = v;
        c.step   = s;
        c.period = per;
        c.amount = 5'(amt);
        c.flag   = flg;
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        return mk_cmd(func_t'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom),
                      int'($urandom_range(16)) - 8, 1'($urandom));
    endfunction

    task automatic push_cmd(cmd_t c);
        queued_cmds = {queued_cmds, c};
    endtask

    task automatic push_ticks(int n, int noise_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_cmd(mk_cmd(func_t'($urandom_range(1, 4)), 8'($urandom), 8'($urandom),
                                8'($urandom_range(1, 4)), int'($urandom_range(16)) - 8,
                                1'($urandom)));
            else
                push_cmd(mk_cmd(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 0, 1'b0));
        end
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= FUNC_TICK;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_results = {pending_results, next_track_state(in_flight)};
                cmds_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_cmds.size() > 0 && $urandom_range(99) >= idle_pct())
                begin
                    in_flight = queued_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, in_flight.flag, in_flight.amount, in_flight.period,
                                      in_flight.step, in_flight.value};
                    s_axis_tuser  <= in_flight.func;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got 0x%08h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    result_t exp_r;
                    exp_r = pending_results.pop_front();
                    check_field("pan_now", exp_r.pan_now, m_axis_tdata[7:0]);
                    check_field("pitch_offset", exp_r.pitch_offset, m_axis_tdata[27:8]);
                    check_field("bend_event", exp_r.bend_event, m_axis_tdata[28]);
                    check_field("lfo_active", exp_r.lfo_active, m_axis_tdata[29]);
                    check_field("env_active", exp_r.env_active, m_axis_tdata[30]);
                end
            end
            m_axis_tready <= $urandom_range(99) >= idle_pct();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int n;
        int per;
        pan_q       = PAN_RESET;
        lfo_lo      = PAN_RESET;
        lfo_hi      = PAN_RESET;
        lfo_inc     = '0;
        lfo_reload  = '0;
        lfo_cnt     = '0;
        lfo_falling = 1'b0;
        lfo_run     = 1'b0;
        env_wait    = '0;
        env_amt     = '0;
        env_int     = '0;
        env_cnt     = '0;
        env_ofs     = '0;
        env_run     = 1'b0;

        // pan clamping, enables with zero step/depth, LFO bounds
        push_cmd(mk_cmd(FUNC_TICK, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_ADJ_PAN, 8'h00, 8'h00, 8'h00, 8, 1'b0));
        push_cmd(mk_cmd(FUNC_SET_PAN, 8'hff, 8'hff, 8'hff, -8, 1'b1));
        push_cmd(mk_cmd(FUNC_ADJ_PAN, 8'h00, 8'h00, 8'h00, -8, 1'b0));
        push_cmd(mk_cmd(FUNC_ADJ_PAN, 8'h00, 8'h00, 8'h00, 8, 1'b0));
        push_cmd(mk_cmd(FUNC_SET_PAN, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_ADJ_PAN, 8'h00, 8'h00, 8'h00, -8, 1'b0));
        push_cmd(mk_cmd(FUNC_LFO_CFG, 8'h7f, 8'h00, 8'h01, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_LFO_ENABLE, 8'h00, 8'h00, 8'h00, 0, 1'b1));
        push_cmd(mk_cmd(FUNC_SET_PAN, 8'h20, 8'h00, 8'h00, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_LFO_CFG, 8'h60, 8'h30, 8'h01, 0, 1'b0));
        push_ticks(4, 0);
        push_cmd(mk_cmd(FUNC_SET_PAN, 8'h50, 8'h00, 8'h00, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_LFO_ENABLE, 8'h00, 8'h00, 8'h00, 0, 1'b1));
        push_cmd(mk_cmd(FUNC_LFO_ENABLE, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        // envelope: interval 0 reloads 255, interval -128 reloads 127
        push_cmd(mk_cmd(FUNC_ENV_CFG, 8'h00, 8'hff, 8'h00, 0, 1'b0));
        push_ticks(2, 0);
        push_cmd(mk_cmd(FUNC_ENV_CFG, 8'h01, 8'h80, 8'h80, 0, 1'b0));
        push_ticks(2, 0);
        push_cmd(mk_cmd(FUNC_ENV_ENABLE, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_ENV_ENABLE, 8'h00, 8'h00, 8'h00, 0, 1'b1));
        push_cmd(mk_cmd(FUNC_NOTE_ON, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_NOTE_ON, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_ENV_CFG, 8'h03, 8'h00, 8'h02, 0, 1'b0));
        push_cmd(mk_cmd(FUNC_ENV_ENABLE, 8'h00, 8'h00, 8'h00, 0, 1'b1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // hold off until the directed part has fully drained
        while (queued_cmds.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
            @(posedge clk);

        n = 0;
        while (n < RAND_ITEMS)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    per = $urandom_range(1, 6);
                    if ($urandom_range(1))
                        per = -per;
                    if ($urandom_range(7) == 0)
                        per = int'($urandom);
                    push_cmd(mk_cmd(FUNC_ENV_CFG, 8'($urandom_range(7)),
                                    ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom),
                                    8'(per), 0, 1'($urandom)));
                    if ($urandom_range(2) == 0)
                        push_cmd(mk_cmd(FUNC_NOTE_ON, 8'($urandom), 8'($urandom),
                                        8'($urandom), 0, 1'($urandom)));
                    per = $urandom_range(5, 20);
                    push_ticks(per, 8);
                    n += per + 1;
                end
                4, 5, 6:
                begin
                    push_cmd(mk_cmd(FUNC_LFO_CFG, 8'($urandom),
                                    ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom),
                                    ($urandom_range(15) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(1, 4)),
                                    0, 1'($urandom)));
                    per = $urandom_range(5, 25);
                    push_ticks(per, 8);
                    n += per + 1;
                end
                default:
                begin
                    push_cmd(rand_cmd());
                    n++;
                end
            endcase
        end

        while (queued_cmds.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d commands and %0d results checked: %0d pitch bends, %0d saturated steps",
                 cmds_taken, results_seen, bends, sat_hits);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tple_pkg.sv
src/tple_core.sv
src/track_pan_lfo_pitch_envelope_unit.sv
sim/tb.sv
